// ===== design/ggnn_pkg.sv =====
package ggnn_pkg;

    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 24;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int NUM_W     = 56;
    localparam int DET_W     = 48;
    localparam int QUO_W     = 16;
    localparam int FRAC_W    = 8;
    localparam int DIST_W    = 24;
    localparam int CNT_W     = 5;
    localparam int N_MUL     = 3;

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MUL_B_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);

    localparam logic REG_GATE_CHI2 = 1'b0;
    localparam logic REG_MAX_DIST  = 1'b1;

    localparam logic [15:0]       GATE_RESET = 16'd2358;
    localparam logic [31:0]       MAXD_RESET = 32'd65536;
    localparam logic [DIST_W-1:0] DIST_SAT   = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CROSS,
        ST_DET,
        ST_DIV,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } seq_ctl_t;

    typedef struct packed {
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

// ===== design/gated_greedy_nn_association.sv =====
// Channel   Valid      Stall      Payload
// input     in_valid   in_stall   track_index .. last_of_cycle
// output    out_valid  out_stall  out_track, matched, match_obs, match_dist
// config    cfg_we     -          cfg_index, cfg_data
//
// Each input word passes the accept cycle, three 24-step bit-serial multiply
// passes (squares, cross terms, determinant) and a 16-step bit-serial divide,
// each with a load cycle, then the decision state, before the next is taken.
// The result register frees the input side; the decision cycle waits only if
// a result is due while the previous one is still stalled.
// Reset clears the used-observation map and the running best at once.
module gated_greedy_nn_association #(
    parameter int MAX_OBS    = 256,
    parameter int MAX_TRACKS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  track_index,
    input  logic [7:0]  obs_index,
    input  logic signed [15:0] innov_x,
    input  logic signed [15:0] innov_y,
    input  logic [23:0] cov_xx,
    input  logic signed [23:0] cov_xy,
    input  logic [23:0] cov_yy,
    input  logic        last_of_track,
    input  logic        last_of_cycle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_track,
    output logic        matched,
    output logic [7:0]  match_obs,
    output logic [23:0] match_dist,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import ggnn_pkg::*;

    localparam int USED_DEPTH = (MAX_OBS < 256) ? MAX_OBS : 256;
    localparam int USED_IW    = $clog2(USED_DEPTH);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    seq_ctl_t          mul_ctl;
    seq_ctl_t          div_ctl;

    logic [15:0]       gate_reg;
    logic [31:0]       maxd_reg;
    logic [USED_DEPTH-1:0] used_reg;
    logic [USED_DEPTH-1:0] used_next;
    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] best_dist_next;
    logic [7:0]        best_obs_reg;
    logic [7:0]        best_obs_next;
    logic              have_best_reg;
    logic              have_best_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [7:0]        trk_reg;
    logic [7:0]        obs_reg;
    logic [15:0]       xm_reg;
    logic [15:0]       ym_reg;
    logic [23:0]       sxx_reg;
    logic [23:0]       sxym_reg;
    logic [23:0]       syy_reg;
    logic              cross_neg_reg;
    logic              last_trk_reg;
    logic              last_cyc_reg;
    logic              eu_ok_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              num_neg_reg;
    logic              det_ok_reg;
    logic [7:0]        out_track_reg;
    logic              matched_reg;
    logic [7:0]        match_obs_reg;
    logic [DIST_W-1:0] match_dist_reg;

    logic [MUL_A_W-1:0] mul_a [N_MUL];
    logic [MUL_B_W-1:0] mul_b [N_MUL];
    logic [MUL_P_W-1:0] mul_p [N_MUL];
    div_res_t           div_res;

    logic               accept;
    logic               out_free;
    logic               leave;
    logic [31:0]        eu2;
    logic signed [57:0] num_s;
    logic [DET_W:0]     det_s;
    logic               trk_ok;
    logic               obs_ok;
    logic               pass;
    logic [DIST_W-1:0]  quo_dist;

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign leave    = !last_trk_reg || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == MUL_STEPS)
                begin
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                if (cnt_reg == MUL_STEPS)
                begin
                    state_next = ST_DET;
                end
            end
            ST_DET:
            begin
                if (cnt_reg == MUL_STEPS)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_STEPS)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (leave)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mul_ctl  = '0;
        div_ctl  = '0;
        cnt_next = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SQ, ST_CROSS, ST_DET:
            begin
                mul_ctl.load = (cnt_reg == '0);
                mul_ctl.step = (cnt_reg != '0);
                cnt_next     = (cnt_reg == MUL_STEPS) ? '0 : cnt_reg + 1'b1;
            end
            ST_DIV:
            begin
                div_ctl.load = (cnt_reg == '0);
                div_ctl.step = (cnt_reg != '0);
                cnt_next     = (cnt_reg == DIV_STEPS) ? '0 : cnt_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // multiplier operands per pass
    always_comb
    begin
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a[0] = {16'd0, xm_reg};
                mul_b[0] = {8'd0, xm_reg};
                mul_a[1] = {16'd0, ym_reg};
                mul_b[1] = {8'd0, ym_reg};
                mul_a[2] = {16'd0, xm_reg};
                mul_b[2] = {8'd0, ym_reg};
            end
            ST_CROSS:
            begin
                mul_a[0] = mul_p[0][MUL_A_W-1:0];
                mul_b[0] = syy_reg;
                mul_a[1] = mul_p[1][MUL_A_W-1:0];
                mul_b[1] = sxx_reg;
                mul_a[2] = mul_p[2][MUL_A_W-1:0];
                mul_b[2] = sxym_reg;
            end
            default:
            begin
                mul_a[0] = {8'd0, sxx_reg};
                mul_b[0] = syy_reg;
                mul_a[1] = {8'd0, sxym_reg};
                mul_b[1] = sxym_reg;
                mul_a[2] = '0;
                mul_b[2] = '0;
            end
        endcase
    end

    for (genvar i = 0; i < N_MUL; i++)
    begin : g_mul
        ggnn_smul u_mul (
            .clk  (clk),
            .ctl  (mul_ctl),
            .a    (mul_a[i]),
            .b    (mul_b[i]),
            .prod (mul_p[i])
        );
    end

    // num = syy*x^2 - 2*sxy*x*y + sxx*y^2, det = sxx*syy - sxy^2
    always_comb
    begin
        eu2   = mul_p[0][31:0] + mul_p[1][31:0];
        num_s = $signed({2'b00, mul_p[0]}) + $signed({2'b00, mul_p[1]});
        if (cross_neg_reg)
        begin
            num_s = num_s + $signed({1'b0, mul_p[2], 1'b0});
        end
        else
        begin
            num_s = num_s - $signed({1'b0, mul_p[2], 1'b0});
        end
        det_s = {1'b0, mul_p[0][DET_W-1:0]} - {1'b0, mul_p[1][DET_W-1:0]};
    end

    ggnn_sdiv u_div (
        .clk (clk),
        .ctl (div_ctl),
        .num (num_reg),
        .den (det_s[DET_W-1:0]),
        .res (div_res)
    );

    // gate and greedy choice
    always_comb
    begin
        trk_ok   = (32'(trk_reg) < MAX_TRACKS);
        obs_ok   = (32'(obs_reg) < MAX_OBS);
        quo_dist = {{(DIST_W-QUO_W){1'b0}}, div_res.quo};
        pass     = trk_ok && obs_ok && det_ok_reg && !num_neg_reg && !div_res.ovf
                   && (div_res.quo < gate_reg) && eu_ok_reg
                   && !used_reg[obs_reg[USED_IW-1:0]]
                   && (!have_best_reg || (quo_dist < best_dist_reg));

        best_dist_next = pass ? quo_dist : best_dist_reg;
        best_obs_next  = pass ? obs_reg : best_obs_reg;
        have_best_next = pass || have_best_reg;

        used_next = used_reg;
        if (last_trk_reg && have_best_next)
        begin
            used_next[best_obs_next[USED_IW-1:0]] = 1'b1;
        end
        if (last_cyc_reg)
        begin
            used_next = '0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if ((state_reg == ST_DECIDE) && leave && last_trk_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gate_reg      <= GATE_RESET;
            maxd_reg      <= MAXD_RESET;
            used_reg      <= '0;
            best_dist_reg <= DIST_SAT;
            best_obs_reg  <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GATE_CHI2: gate_reg <= cfg_data[15:0];
                    REG_MAX_DIST:  maxd_reg <= cfg_data;
                    default:       gate_reg <= gate_reg;
                endcase
            end
            if ((state_reg == ST_DECIDE) && leave)
            begin
                used_reg <= used_next;
                if (last_trk_reg)
                begin
                    best_dist_reg <= DIST_SAT;
                    best_obs_reg  <= '0;
                    have_best_reg <= 1'b0;
                end
                else
                begin
                    best_dist_reg <= best_dist_next;
                    best_obs_reg  <= best_obs_next;
                    have_best_reg <= have_best_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trk_reg       <= track_index;
            obs_reg       <= obs_index;
            xm_reg        <= innov_x[15] ? 16'(~innov_x + 16'sd1) : innov_x;
            ym_reg        <= innov_y[15] ? 16'(~innov_y + 16'sd1) : innov_y;
            sxx_reg       <= cov_xx;
            sxym_reg      <= cov_xy[23] ? 24'(~cov_xy + 24'sd1) : cov_xy;
            syy_reg       <= cov_yy;
            cross_neg_reg <= cov_xy[23] ^ innov_x[15] ^ innov_y[15];
            last_trk_reg  <= last_of_track;
            last_cyc_reg  <= last_of_cycle;
        end
        if ((state_reg == ST_CROSS) && (cnt_reg == '0))
        begin
            eu_ok_reg <= (eu2 < maxd_reg);
        end
        if ((state_reg == ST_DET) && (cnt_reg == '0))
        begin
            num_neg_reg <= num_s[57];
            num_reg     <= num_s[NUM_W-1:0];
        end
        if ((state_reg == ST_DIV) && (cnt_reg == '0))
        begin
            det_ok_reg <= !det_s[DET_W] && (det_s[DET_W-1:0] != '0);
        end
        if ((state_reg == ST_DECIDE) && leave && last_trk_reg)
        begin
            out_track_reg  <= trk_reg;
            matched_reg    <= have_best_next;
            match_obs_reg  <= have_best_next ? best_obs_next : 8'd0;
            match_dist_reg <= have_best_next ? best_dist_next : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_track  = out_track_reg;
    assign matched    = matched_reg;
    assign match_obs  = match_obs_reg;
    assign match_dist = match_dist_reg;

endmodule

// ===== design/ggnn_smul.sv =====
module ggnn_smul (
    input  logic                     clk,
    input  ggnn_pkg::seq_ctl_t       ctl,
    input  logic [ggnn_pkg::MUL_A_W-1:0] a,
    input  logic [ggnn_pkg::MUL_B_W-1:0] b,
    output logic [ggnn_pkg::MUL_P_W-1:0] prod
);
    import ggnn_pkg::*;

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic [MUL_P_W-1:0] acc_next;

    // msb-first shift-add, one multiplier bit per cycle
    always_comb
    begin
        acc_next = {acc_reg[MUL_P_W-2:0], 1'b0};
        if (b_reg[MUL_B_W-1])
        begin
            acc_next = acc_next + {{MUL_B_W{1'b0}}, a_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (ctl.step)
        begin
            b_reg   <= {b_reg[MUL_B_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;

endmodule

// ===== design/ggnn_sdiv.sv =====
module ggnn_sdiv (
    input  logic                       clk,
    input  ggnn_pkg::seq_ctl_t         ctl,
    input  logic [ggnn_pkg::NUM_W-1:0] num,
    input  logic [ggnn_pkg::DET_W-1:0] den,
    output ggnn_pkg::div_res_t         res
);
    import ggnn_pkg::*;

    logic [DET_W-1:0]  den_reg;
    logic [DET_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  lo_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ovf_reg;
    logic [DET_W:0]    rem_sh;
    logic [DET_W:0]    rem_sub;
    logic              qbit;

    // restoring division of num*2^8 by den, one quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, lo_reg[QUO_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        qbit    = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            den_reg <= den;
            rem_reg <= num[NUM_W-1:FRAC_W];
            lo_reg  <= {num[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
            quo_reg <= '0;
            ovf_reg <= (num[NUM_W-1:FRAC_W] >= den);
        end
        else if (ctl.step)
        begin
            rem_reg <= qbit ? rem_sub[DET_W-1:0] : rem_sh[DET_W-1:0];
            lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign res.ovf = ovf_reg;
    assign res.quo = quo_reg;

endmodule
